>>> hdl/tcls_pkg.sv
// ----------------------------------------------------------------------------
// Touch press classifier package
// Shared item types, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcls_pkg;

    // Field and storage widths fixed by the item format.
    localparam int BTN_W     = 3;
    localparam int CHAN_W    = 4;
    localparam int TICK_W    = 16;
    localparam int TIME_W    = 32;
    localparam int MAP_SLOTS = 5;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAP0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP4     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 3'd6;

    // Register reset values.
    localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [TICK_W-1:0] LONG_RST     = 16'd500;

    // Input function and press kind codes.
    localparam logic FUNC_TOUCH = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    // One input item.
    typedef struct packed {
        logic              func;
        logic [CHAN_W-1:0] channel;
        logic              touch_active;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic             press_kind;
        logic             last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic match;
        logic deb;
        logic upd;
        logic scan;
        logic load_ev;
        logic load_tk;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic found;
        logic deb_ok;
        logic emit;
        logic scan_last;
        logic mask_any;
        logic mask_single;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/tcls_ctrl.sv
// ----------------------------------------------------------------------------
// Touch press classifier controller
// Sequences the event path, the tick scan and the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcls_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_func,
    output logic               o_in_ready,
    input  wire logic          i_out_free,
    input  wire tcls_pkg::t_sts i_sts,
    output tcls_pkg::t_cmd     o_cmd
);
    import tcls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EV_MATCH,
        S_EV_DEB,
        S_EV_UPD,
        S_EV_OUT,
        S_TK_SCAN,
        S_TK_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_in_func == FUNC_TICK) ? S_TK_SCAN : S_EV_MATCH;
                end
            end
            S_EV_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_EV_DEB;
            end
            S_EV_DEB: begin
                if (i_sts.found) begin
                    o_cmd.deb = 1'b1;
                    n_state   = S_EV_UPD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EV_UPD: begin
                if (i_sts.deb_ok) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_EV_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EV_OUT: begin
                if (!i_sts.emit) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_cmd.load_ev = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_TK_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_TK_OUT;
                end
            end
            S_TK_OUT: begin
                if (!i_sts.mask_any) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_cmd.load_tk = 1'b1;
                    if (i_sts.mask_single) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hdl/tcls_dp.sv
// ----------------------------------------------------------------------------
// Touch press classifier datapath
// Holds configuration, time and per-button press state, and forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module tcls_dp #(
    parameter int BUTTONS = 5
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tcls_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tcls_pkg::TICK_W-1:0]        i_cfg_data,
    input  wire tcls_pkg::t_in_item                 i_in,
    input  wire tcls_pkg::t_cmd                     i_cmd,
    output tcls_pkg::t_sts                          o_sts,
    output tcls_pkg::t_out_item                     o_res
);
    import tcls_pkg::*;

    localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    // Configuration registers.
    logic [CHAN_W-1:0] r_map [MAP_SLOTS];
    logic [TICK_W-1:0] r_deb;
    logic [TICK_W-1:0] r_long;

    // Time and per-button state.
    logic [TIME_W-1:0] r_time;
    logic [BUTTONS-1:0] r_held;
    logic [BUTTONS-1:0] r_lr;
    logic [TIME_W-1:0] r_start [BUTTONS];
    logic [TIME_W-1:0] r_last  [BUTTONS];

    // Working registers.
    t_in_item          r_item;
    logic [IW-1:0]     r_btn;
    logic              r_found;
    logic              r_deb_ok;
    logic              r_emit;
    logic              r_kind;
    logic [IW-1:0]     r_idx;
    logic [BUTTONS-1:0] r_mask;

    logic [IW-1:0]      w_match_btn;
    logic               w_match_found;
    logic [IW-1:0]      w_low;
    logic [BUTTONS-1:0] w_mask_rest;
    logic [TIME_W-1:0]  w_deb_diff;
    logic [TIME_W-1:0]  w_hold_diff;
    logic [TIME_W-1:0]  w_scan_diff;
    logic               w_scan_hit;

    // Channel lookup: the lowest button whose channel matches wins.
    always_comb begin
        w_match_btn   = '0;
        w_match_found = 1'b0;
        for (int i = BUTTONS - 1; i >= 0; i--) begin
            if (r_map[i] == r_item.channel) begin
                w_match_btn   = IW'(i);
                w_match_found = 1'b1;
            end
        end
    end

    // Lowest pending long press of a tick, and what remains after it.
    always_comb begin
        w_low = '0;
        for (int i = BUTTONS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_low = IW'(i);
            end
        end
    end

    assign w_mask_rest = r_mask & (r_mask - BUTTONS'(1));

    // Wrapping time differences.
    assign w_deb_diff  = r_time - r_last[r_btn];
    assign w_hold_diff = r_time - r_start[r_btn];
    assign w_scan_diff = r_time - r_start[r_idx];
    assign w_scan_hit  = r_held[r_idx] && !r_lr[r_idx] &&
                         (w_scan_diff >= TIME_W'(r_long));

    // Status toward the controller.
    always_comb begin
        o_sts.found       = r_found;
        o_sts.deb_ok      = r_deb_ok;
        o_sts.emit        = r_emit;
        o_sts.scan_last   = (r_idx == IW'(BUTTONS - 1));
        o_sts.mask_any    = |r_mask;
        o_sts.mask_single = (w_mask_rest == '0);
    end

    // Result formed for the output register.
    always_comb begin
        if (i_cmd.load_tk) begin
            o_res.button     = BTN_W'(w_low);
            o_res.press_kind = KIND_LONG;
            o_res.last       = (w_mask_rest == '0);
        end else begin
            o_res.button     = BTN_W'(r_btn);
            o_res.press_kind = r_kind;
            o_res.last       = 1'b1;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_SLOTS; i++) begin
                r_map[i] <= CHAN_W'(i + 1);
            end
            r_deb  <= DEBOUNCE_RST;
            r_long <= LONG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                REG_MAP0, REG_MAP1, REG_MAP2, REG_MAP3, REG_MAP4: begin
                    r_map[i_cfg_index] <= i_cfg_data[CHAN_W-1:0];
                end
                REG_DEBOUNCE: begin
                    r_deb <= i_cfg_data;
                end
                REG_LONG: begin
                    r_long <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Item capture and event working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
        if (i_cmd.match) begin
            r_btn   <= w_match_btn;
            r_found <= w_match_found;
        end
        if (i_cmd.deb) begin
            r_deb_ok <= (w_deb_diff >= TIME_W'(r_deb));
        end
        if (i_cmd.upd) begin
            r_emit <= !r_item.touch_active && r_held[r_btn] && !r_lr[r_btn];
            r_kind <= (w_hold_diff >= TIME_W'(r_long)) ? KIND_LONG : KIND_SHORT;
        end
    end

    // Time, per-button state and the tick scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_held <= '0;
            r_lr   <= '0;
            r_mask <= '0;
            r_idx  <= '0;
            for (int i = 0; i < BUTTONS; i++) begin
                r_start[i] <= '0;
                r_last[i]  <= '0;
            end
        end else begin
            // A tick advances time and restarts the scan.
            if (i_cmd.capture && i_in.func == FUNC_TICK) begin
                r_time <= r_time + TIME_W'(1);
                r_idx  <= '0;
                r_mask <= '0;
            end
            // One button per cycle is checked against the long threshold.
            if (i_cmd.scan) begin
                r_idx <= r_idx + IW'(1);
                if (w_scan_hit) begin
                    r_lr[r_idx]   <= 1'b1;
                    r_mask[r_idx] <= 1'b1;
                end
            end
            // Each transferred long press leaves the pending set.
            if (i_cmd.load_tk) begin
                r_mask <= w_mask_rest;
            end
            // An accepted touch event updates the button's press state.
            if (i_cmd.upd) begin
                r_last[r_btn] <= r_time;
                if (r_item.touch_active) begin
                    r_held[r_btn]  <= 1'b1;
                    r_start[r_btn] <= r_time;
                    r_lr[r_btn]    <= 1'b0;
                end else begin
                    r_held[r_btn] <= 1'b0;
                    r_lr[r_btn]   <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/touch_press_classifier.sv
// ----------------------------------------------------------------------------
// Touch press classifier
// Classifies touch events per button into short and long presses.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------
//   input   | i_in_valid / o_in_ready    | i_in (func, channel, touch_active)
//   result  | o_out_valid / i_out_ready  | o_out (button, press_kind, last)
//   config  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A touch event passes from its transfer through channel lookup,
// debounce compare, state update and the load of its result.
// A tick scans the button state, one button per cycle through a single
// subtract-and-compare, then loads one result per long press reported,
// each when the result register is free.
// A result load waits while the result register holds an untaken result.
// The result register lets a new item be taken while a result waits.
// Reset is synchronous, active low; configuration is ready in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_press_classifier #(
    parameter int BUTTONS = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire tcls_pkg::t_in_item             i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output tcls_pkg::t_out_item                 o_out,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tcls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tcls_pkg::TICK_W-1:0]    i_cfg_data
);
    import tcls_pkg::*;

    t_cmd      w_cmd;
    t_sts      w_sts;
    t_out_item w_res;
    logic      w_out_free;
    logic      r_out_valid;
    t_out_item r_out;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Sequencer.
    tcls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in.func),
        .o_in_ready (o_in_ready),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    tcls_dp #(
        .BUTTONS (BUTTONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res       (w_res)
    );

    // Result output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.load_ev || w_cmd.load_tk) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.load_ev || w_cmd.load_tk) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // A result is loaded only when the output register is free.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_ev || w_cmd.load_tk) |-> w_out_free)
        else $error("result loaded over a pending transfer");

    // Event and tick results never load together.
    a_load_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load_ev && w_cmd.load_tk))
        else $error("event and tick results loaded together");

    // No result is loaded while the block takes a new item.
    a_idle_noload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(w_cmd.load_ev || w_cmd.load_tk))
        else $error("result loaded while idle");

    // An accepted item keeps the input closed in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");
`endif

endmodule

`default_nettype wire
